// ===== rtl/dct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_pkg: shared types and codon table for the codon translator
// Holds the codon request type and the standard genetic code lookup,
// including the IUPAC ambiguity codons that use N, R, Y and H.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CountW = 2;

  localparam logic [CharW-1:0] STOP_CHAR = 8'h2A;

  typedef struct packed {
    logic [CharW-1:0] b0;
    logic [CharW-1:0] b1;
    logic [CharW-1:0] b2;
    logic             last;
  } codon_t;

  function automatic logic [CharW-1:0] lookup_codon(input logic [3*CharW-1:0] codon);
    logic [CharW-1:0] aa;
    case (codon)
      "ACA", "ACG", "ACT", "ACC", "ACN": aa = "T";
      "GAA", "GAG", "GAR": aa = "E";
      "CTG", "CTA", "CTT", "CTN", "CTC", "TTG", "YTR", "TTA", "TTR": aa = "L";
      "TGY", "TGC", "TGT": aa = "C";
      "GGY", "GGG", "GGN", "GGT", "GGR", "GGA", "GGC": aa = "G";
      "AGY", "TCT", "AGC", "TCG", "TCC", "AGT", "TCA", "TCN": aa = "S";
      "TTC", "TTY", "TTT": aa = "F";
      "GCG", "GCC", "GCR", "GCN", "GCT", "GCY", "GCA": aa = "A";
      "GAT", "GAC", "GAY": aa = "D";
      "TAT", "TAC", "TAY": aa = "Y";
      "CGT", "AGA", "CGC", "CGA", "CGG", "AGG", "CGN": aa = "R";
      "TAA", "TAR", "TAG", "TGA": aa = STOP_CHAR;
      "CAC", "CAY", "CAT": aa = "H";
      "ATG": aa = "M";
      "GTR", "GTY", "GTA", "GTN", "GTG", "GTT", "GTC": aa = "V";
      "CAR", "CAG", "CAA": aa = "Q";
      "ATC", "ATT", "ATA", "ATH": aa = "I";
      "CCR", "CCY", "CCT", "CCG", "CCC", "CCN", "CCA": aa = "P";
      "AAR", "AAA", "AAG": aa = "K";
      "TGG": aa = "W";
      "AAC", "AAY", "AAT": aa = "N";
      default: aa = STOP_CHAR;
    endcase
    return aa;
  endfunction

endpackage

// ===== rtl/dct_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_framer: frame offset skip and codon assembly
// Counts skipped bases, holds the first two bases of a codon and registers
// each completed codon as a request for the lookup stage.
// ----------------------------------------------------------------------------
module dct_framer
  import dct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             accept_i,
  input  logic [CharW-1:0] base_char_i,
  input  logic             last_base_i,
  input  logic             advance_i,
  output logic             codon_valid_o,
  output codon_t           codon_o
);

  logic [CountW-1:0] offset_q;
  logic [CountW-1:0] skipped_q, skipped_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic [CharW-1:0]  held_q [2];
  logic              hold_we;
  logic              complete;
  logic              codon_valid_q, codon_valid_d;
  codon_t            codon_q;

  always_comb begin
    skipped_d = skipped_q;
    fill_d    = fill_q;
    hold_we   = 1'b0;
    complete  = 1'b0;
    if (accept_i) begin
      if (skipped_q < offset_q) begin
        skipped_d = skipped_q + 2'd1;
      end else if (fill_q < 2'd2) begin
        hold_we = 1'b1;
        fill_d  = fill_q + 2'd1;
      end else begin
        complete = 1'b1;
        fill_d   = '0;
      end
      if (last_base_i) begin
        skipped_d = '0;
        fill_d    = '0;
      end
    end
  end

  always_comb begin
    codon_valid_d = codon_valid_q;
    if (advance_i) begin
      codon_valid_d = 1'b0;
    end
    if (complete) begin
      codon_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q      <= '0;
      skipped_q     <= '0;
      fill_q        <= '0;
      codon_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      skipped_q     <= skipped_d;
      fill_q        <= fill_d;
      codon_valid_q <= codon_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      held_q[fill_q[0]] <= base_char_i;
    end
    if (complete) begin
      codon_q <= '{b0: held_q[0], b1: held_q[1], b2: base_char_i, last: last_base_i};
    end
  end

  assign codon_valid_o = codon_valid_q;
  assign codon_o       = codon_q;

endmodule

// ===== rtl/dct_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_lookup: codon table lookup and result register
// Translates the pending codon request and holds the amino acid until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module dct_lookup
  import dct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             codon_valid_i,
  input  codon_t           codon_i,
  output logic             advance_o,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [CharW-1:0] amino_char_o,
  output logic             ends_transcript_o
);

  logic             valid_q, valid_d;
  logic [CharW-1:0] amino_q;
  logic             ends_q;
  logic             out_free;

  assign out_free  = !valid_q || !stall_i;
  assign advance_o = codon_valid_i && out_free;

  always_comb begin
    valid_d = valid_q;
    if (out_free) begin
      valid_d = codon_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      amino_q <= lookup_codon({codon_i.b0, codon_i.b1, codon_i.b2});
      ends_q  <= codon_i.last;
    end
  end

  assign valid_o           = valid_q;
  assign amino_char_o      = amino_q;
  assign ends_transcript_o = ends_q;

endmodule

// ===== rtl/dct_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_codon_translator_top: streaming DNA codon to amino acid translator
// Takes one ASCII base per request and emits one amino acid per codon.
// ----------------------------------------------------------------------------
// Accepts one base every cycle unless stall_o is high. A base that completes a
// codon is registered, looked up in the constant genetic code table, and moves
// into the output register once that register is free or being drained. Input
// stalls only when both the codon register and the output register are full
// and the output is stalled.
// frame_offset leading bases of each transcript are skipped; a trailing
// partial codon is dropped.
module dna_codon_translator_top
  import dct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [CharW-1:0] base_char_i,
  input  logic             last_base_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [CharW-1:0] amino_char_o,
  output logic             ends_transcript_o
);

  logic   accept;
  logic   advance;
  logic   codon_valid;
  codon_t codon;

  assign stall_o = codon_valid && !advance;
  assign accept  = valid_i && !stall_o;

  dct_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .base_char_i   (base_char_i),
    .last_base_i   (last_base_i),
    .advance_i     (advance),
    .codon_valid_o (codon_valid),
    .codon_o       (codon)
  );

  dct_lookup u_lookup (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .codon_valid_i     (codon_valid),
    .codon_i           (codon),
    .advance_o         (advance),
    .valid_o           (valid_o),
    .stall_i           (stall_i),
    .amino_char_o      (amino_char_o),
    .ends_transcript_o (ends_transcript_o)
  );

`ifndef ASSERT_OFF
  a_stall_needs_codon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (codon_valid && valid_o && stall_i))
    else $error("input stalled without a blocked codon");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> valid_o)
    else $error("advanced codon did not reach output");

  a_drain_empties_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !codon_valid) |=> !valid_o)
    else $error("result repeated after being taken");
`endif

endmodule
